>>> hdl/jsml_pkg.sv
// Package for the joint setpoint motion limiter.
// Holds op codes, register indexes, configuration type and the
// command/status structs between controller and datapath. No dependencies.
package jsml_pkg;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_RESET  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [2:0] REG_LOWER = 3'd0;
  localparam logic [2:0] REG_UPPER = 3'd1;
  localparam logic [2:0] REG_SPEED = 3'd2;
  localparam logic [2:0] REG_ACCEL = 3'd3;
  localparam logic [2:0] REG_TRACK = 3'd4;

  localparam int SQRT_STEPS = 29;
  localparam int DIV_STEPS  = 50;

  typedef struct packed {
    logic signed [23:0] lower;
    logic signed [23:0] upper;
    logic [22:0]        speed;
    logic [27:0]        accel;
    logic [22:0]        track;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic pre;
    logic mul1;
    logic mul2;
    logic mul3;
    logic sqrt_step;
    logic vel1;
    logic vel2;
    logic pos1;
    logic pos2;
    logic div_step;
    logic fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic short_op;
    logic clip;
  } stat_t;

endpackage

>>> hdl/jsml_if.sv
// Request channel interfaces for the joint setpoint motion limiter.
// Valid/ready handshake with payload; no package dependency.
interface jsml_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [23:0] raw_goal;
  logic signed [23:0] measured_pos;
  logic [23:0]        step_time;
  modport source (output valid, op, raw_goal, measured_pos, step_time, input ready);
  modport sink   (input valid, op, raw_goal, measured_pos, step_time, output ready);
endinterface

interface jsml_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] safe_pos;
  logic signed [23:0] safe_speed;
  logic               valid_res;
  logic               pos_clipped;
  logic               speed_clipped;
  logic               accel_clipped;
  logic               track_clipped;
  logic [23:0]        goal_gap;
  modport source (output valid, safe_pos, safe_speed, valid_res, pos_clipped,
                  speed_clipped, accel_clipped, track_clipped, goal_gap, input ready);
  modport sink   (input valid, safe_pos, safe_speed, valid_res, pos_clipped,
                  speed_clipped, accel_clipped, track_clipped, goal_gap, output ready);
endinterface

>>> hdl/jsml_ctrl.sv
// Sequencer for the joint setpoint motion limiter.
// Steps the datapath through one request; owns the channel handshakes.
// Depends on jsml_pkg.
module jsml_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  jsml_pkg::stat_t stat,
  output jsml_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PRE  = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_MUL3 = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_VEL1 = 4'd6;
  localparam logic [3:0] S_VEL2 = 4'd7;
  localparam logic [3:0] S_POS1 = 4'd8;
  localparam logic [3:0] S_POS2 = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;
  localparam logic [3:0] S_EMIT = 4'd12;

  localparam logic [5:0] SQRT_LAST = 6'(jsml_pkg::SQRT_STEPS - 1);
  localparam logic [5:0] DIV_LAST  = 6'(jsml_pkg::DIV_STEPS - 1);

  logic [3:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign emit_ok   = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.load  = in_valid && (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PRE;
      end
      S_PRE: begin
        cmd.pre   = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        // short requests already have their result
        if (stat.short_op) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.mul1  = 1'b1;
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 6'd1;
        if (cnt_r == SQRT_LAST) state_nxt = S_VEL1;
      end
      S_VEL1: begin
        cmd.vel1  = 1'b1;
        state_nxt = S_VEL2;
      end
      S_VEL2: begin
        cmd.vel2  = 1'b1;
        state_nxt = S_POS1;
      end
      S_POS1: begin
        cmd.pos1  = 1'b1;
        state_nxt = S_POS2;
      end
      S_POS2: begin
        cmd.pos2  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!stat.clip) begin
          state_nxt = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + 6'd1;
          if (cnt_r == DIV_LAST) state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_ok) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/jsml_dp.sv
// Datapath for the joint setpoint motion limiter.
// Held state, shared product register, serial square root and divider.
// Depends on jsml_pkg.
module jsml_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  jsml_pkg::cmd_t     cmd,
  input  jsml_pkg::cfg_t     cfg,
  input  logic [1:0]         in_op,
  input  logic signed [23:0] in_raw_goal,
  input  logic signed [23:0] in_measured_pos,
  input  logic [23:0]        in_step_time,
  output jsml_pkg::stat_t    stat,
  output logic signed [23:0] out_safe_pos,
  output logic signed [23:0] out_safe_speed,
  output logic               out_valid_res,
  output logic               out_pos_clipped,
  output logic               out_speed_clipped,
  output logic               out_accel_clipped,
  output logic               out_track_clipped,
  output logic [23:0]        out_goal_gap
);

  localparam logic signed [31:0] SPD_MAX = 32'sd8388607;
  localparam logic signed [31:0] SPD_MIN = -32'sd8388608;
  localparam logic [54:0]        HALF_DT = 55'd1 << 23;

  function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    logic signed [31:0] t;
    t = (v < hi) ? v : hi;
    return (t > lo) ? t : lo;
  endfunction

  // captured request
  logic [1:0]         op_r;
  logic signed [23:0] raw_r, meas_r;
  logic [23:0]        dt_r;
  // held state
  logic signed [23:0] held_pos_r, held_speed_r;
  logic               primed_r;
  // working registers
  logic signed [31:0] dest_r, tlo_r, thi_r, desired_r, nv_r, np_r;
  logic               pf_r, tf_r, vf_r, af_r, clip_r, neg_r;
  logic [25:0]        errmag_r;
  logic               errneg_r;
  logic [53:0]        prod_r;
  logic [28:0]        adt_r;
  logic [57:0]        x_r, r_r, bit_r;
  logic [49:0]        num_r, q_r;
  logic [24:0]        rem_r;
  // finished result, then output register
  logic signed [23:0] wpos_r, wspd_r;
  logic               wvalid_r, wpf_r, wvf_r, waf_r, wtf_r;
  logic [23:0]        wgap_r;

  logic signed [31:0] lower32, upper32, spd32, trk32, adt32, meas32, raw32, hp32, hs32;
  logic signed [31:0] rst_pos, d1, tlo, thi, b1, err;
  logic [57:0]        adt_sq, trial;
  logic signed [31:0] stop, stopc, m, dv, lim, nv0, nvc;
  logic [23:0]        nvmag, stepmag;
  logic signed [31:0] step32, np0, slo, shi, b2, dd, gap32, qsig;
  logic [25:0]        rem2;
  logic signed [23:0] nv_fin;
  logic               is_short;

  assign lower32 = 32'(cfg.lower);
  assign upper32 = 32'(cfg.upper);
  assign spd32   = $signed({9'd0, cfg.speed});
  assign trk32   = $signed({9'd0, cfg.track});
  assign adt32   = $signed({3'd0, adt_r});
  assign meas32  = 32'(meas_r);
  assign raw32   = 32'(raw_r);
  assign hp32    = 32'(held_pos_r);
  assign hs32    = 32'(held_speed_r);

  assign is_short = (op_r != jsml_pkg::OP_UPDATE) || (dt_r == '0);
  assign stat.short_op = is_short;
  assign stat.clip     = clip_r;

  always_comb begin
    rst_pos = clamp32(meas32, lower32, upper32);
    d1      = clamp32(raw32, lower32, upper32);
    tlo     = meas32 - trk32;
    thi     = meas32 + trk32;
    b1      = clamp32(d1, tlo, thi);
    err     = dest_r - hp32;
    adt_sq  = adt_r * adt_r;
    trial   = r_r + bit_r;
    // stopping speed and its cap
    stop    = $signed({3'd0, r_r[28:0]}) - adt32;
    stopc   = (stop < 0) ? 32'sd0 : stop;
    m       = (stopc < spd32) ? stopc : spd32;
    // acceleration step and speed cap
    dv      = desired_r - hs32;
    lim     = clamp32(dv, -adt32, adt32);
    nv0     = hs32 + lim;
    nvc     = clamp32(nv0, -spd32, spd32);
    nvmag   = (nv_r < 0) ? 24'(-nv_r) : 24'(nv_r);
    // integrate and clip to the safe window
    stepmag = 24'((55'(prod_r) + HALF_DT) >> 24);
    step32  = neg_r ? -$signed({8'd0, stepmag}) : $signed({8'd0, stepmag});
    np0     = hp32 + step32;
    slo     = (lower32 > tlo_r) ? lower32 : tlo_r;
    shi     = (upper32 < thi_r) ? upper32 : thi_r;
    b2      = clamp32(np0, slo, shi);
    dd      = b2 - hp32;
    rem2    = {rem_r, num_r[49]};
    // saturate the recomputed speed
    if (q_r > 50'(SPD_MAX)) qsig = neg_r ? SPD_MIN : SPD_MAX;
    else qsig = neg_r ? -$signed(32'(q_r)) : $signed(32'(q_r));
    if (neg_r && q_r > 50'd8388608) qsig = SPD_MIN;
    nv_fin  = clip_r ? 24'(qsig) : 24'(nv_r);
    gap32   = raw32 - np_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_pos_r   <= '0;
      held_speed_r <= '0;
      primed_r     <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_r   <= in_op;
        raw_r  <= in_raw_goal;
        meas_r <= in_measured_pos;
        dt_r   <= in_step_time;
      end
      if (cmd.pre) begin
        wvalid_r <= 1'b0;
        wpf_r    <= 1'b0;
        wvf_r    <= 1'b0;
        waf_r    <= 1'b0;
        wtf_r    <= 1'b0;
        wgap_r   <= '0;
        vf_r     <= 1'b0;
        af_r     <= 1'b0;
        dest_r   <= b1;
        tlo_r    <= tlo;
        thi_r    <= thi;
        pf_r     <= (d1 != raw32);
        tf_r     <= (b1 != d1);
        case (op_r)
          jsml_pkg::OP_CLEAR: begin
            held_pos_r   <= '0;
            held_speed_r <= '0;
            primed_r     <= 1'b0;
            wpos_r       <= '0;
            wspd_r       <= '0;
          end
          jsml_pkg::OP_RESET: begin
            held_pos_r   <= 24'(rst_pos);
            held_speed_r <= '0;
            primed_r     <= 1'b1;
            wpos_r       <= 24'(rst_pos);
            wspd_r       <= '0;
          end
          jsml_pkg::OP_UPDATE: begin
            if (dt_r == '0) begin
              wpos_r <= primed_r ? held_pos_r : meas_r;
              wspd_r <= primed_r ? held_speed_r : '0;
            end else if (!primed_r) begin
              // first update acts as a reset to the measured position
              held_pos_r   <= 24'(rst_pos);
              held_speed_r <= '0;
              primed_r     <= 1'b1;
            end
          end
          default: begin
            wpos_r <= held_pos_r;
            wspd_r <= held_speed_r;
          end
        endcase
      end
      if (cmd.mul1) begin
        errneg_r <= (err < 0);
        errmag_r <= (err < 0) ? 26'(-err) : 26'(err);
        prod_r   <= cfg.accel * dt_r;
      end
      if (cmd.mul2) begin
        adt_r  <= 29'((55'(prod_r) + HALF_DT) >> 24);
        prod_r <= cfg.accel * errmag_r;
      end
      if (cmd.mul3) begin
        x_r   <= adt_sq + {3'd0, prod_r, 1'b0};
        r_r   <= '0;
        bit_r <= 58'd1 << 56;
      end
      if (cmd.sqrt_step) begin
        if (x_r >= trial) begin
          x_r <= x_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      if (cmd.vel1) begin
        if (errneg_r) desired_r <= -m;
        else if (errmag_r != '0) desired_r <= m;
        else desired_r <= '0;
        vf_r <= (stopc > spd32);
      end
      if (cmd.vel2) begin
        af_r <= (lim != dv);
        if (nv0 > spd32 || nv0 < -spd32) begin
          nv_r <= nvc;
          vf_r <= 1'b1;
        end else begin
          nv_r <= nv0;
        end
      end
      if (cmd.pos1) begin
        neg_r  <= (nv_r < 0);
        prod_r <= nvmag * dt_r;
      end
      if (cmd.pos2) begin
        clip_r <= (b2 != np0);
        np_r   <= b2;
        num_r  <= {(dd < 0) ? 26'(-dd) : 26'(dd), 24'd0} + 50'(dt_r >> 1);
        rem_r  <= '0;
        q_r    <= '0;
        if (b2 != np0) begin
          neg_r <= (dd < 0);
          if (b2 == tlo_r || b2 == thi_r) tf_r <= 1'b1;
          if (b2 == lower32 || b2 == upper32) pf_r <= 1'b1;
        end
      end
      if (cmd.div_step) begin
        num_r <= num_r << 1;
        if (rem2 >= {2'd0, dt_r}) begin
          rem_r <= 25'(rem2 - {2'd0, dt_r});
          q_r   <= {q_r[48:0], 1'b1};
        end else begin
          rem_r <= rem2[24:0];
          q_r   <= {q_r[48:0], 1'b0};
        end
      end
      if (cmd.fin) begin
        held_pos_r   <= 24'(np_r);
        held_speed_r <= nv_fin;
        wpos_r       <= 24'(np_r);
        wspd_r       <= nv_fin;
        wvalid_r     <= 1'b1;
        wpf_r        <= pf_r;
        wvf_r        <= vf_r;
        waf_r        <= af_r;
        wtf_r        <= tf_r;
        wgap_r       <= (gap32 < 0) ? 24'(-gap32) : 24'(gap32);
      end
      if (cmd.emit) begin
        out_safe_pos      <= wpos_r;
        out_safe_speed    <= wspd_r;
        out_valid_res     <= wvalid_r;
        out_pos_clipped   <= wpf_r;
        out_speed_clipped <= wvf_r;
        out_accel_clipped <= waf_r;
        out_track_clipped <= wtf_r;
        out_goal_gap      <= wgap_r;
      end
    end
  end

endmodule

>>> hdl/joint_setpoint_motion_limiter_unit.sv
// Top level of the joint setpoint motion limiter: register file, controller
// and datapath. Depends on jsml_pkg, jsml_in_if, jsml_out_if, jsml_ctrl, jsml_dp.
//
//   channel | direction | handshake           | carries
//   in_ch   | sink      | valid/ready         | op, raw_goal, measured_pos, step_time
//   out_ch  | source    | valid/ready         | safe position, speed, flags, goal gap
//   cfg_    | slave     | APB, pready tied 1  | five limit registers at 4*index
//
// A reset, clear, no-op or zero-step request skips the arithmetic and is
// emitted after the preset. An update runs the 29-step square root, and the
// 50-step restoring divider as well when the position is clipped. Reset
// (synchronous, rst_n low) clears the held state and the registers to their
// defaults. A waiting result holds in the output register while the next
// request is accepted; the sequencer stalls only at its end.
module joint_setpoint_motion_limiter_unit (
  input  logic              clk,
  input  logic              rst_n,
  jsml_in_if.sink           in_ch,
  jsml_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  jsml_pkg::cfg_t  cfg_r;
  jsml_pkg::cmd_t  cmd;
  jsml_pkg::stat_t stat;
  logic            cfg_wr;
  logic [2:0]      cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  // register writes; addresses beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lower <= -24'sd3041602;
      cfg_r.upper <= 24'sd3041602;
      cfg_r.speed <= 23'd2197815;
      cfg_r.accel <= 28'd8388608;
      cfg_r.track <= 23'd125829;
    end else if (cfg_wr) begin
      case (cfg_idx)
        jsml_pkg::REG_LOWER: cfg_r.lower <= cfg_pwdata[23:0];
        jsml_pkg::REG_UPPER: cfg_r.upper <= cfg_pwdata[23:0];
        jsml_pkg::REG_SPEED: cfg_r.speed <= cfg_pwdata[22:0];
        jsml_pkg::REG_ACCEL: cfg_r.accel <= cfg_pwdata[27:0];
        jsml_pkg::REG_TRACK: cfg_r.track <= cfg_pwdata[22:0];
        default: ;
      endcase
    end
  end

  // read back the stored bits, zero-extended
  always_comb begin
    case (cfg_idx)
      jsml_pkg::REG_LOWER: cfg_prdata = {8'd0, cfg_r.lower};
      jsml_pkg::REG_UPPER: cfg_prdata = {8'd0, cfg_r.upper};
      jsml_pkg::REG_SPEED: cfg_prdata = {9'd0, cfg_r.speed};
      jsml_pkg::REG_ACCEL: cfg_prdata = {4'd0, cfg_r.accel};
      jsml_pkg::REG_TRACK: cfg_prdata = {9'd0, cfg_r.track};
      default:             cfg_prdata = '0;
    endcase
  end

  jsml_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  jsml_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg               (cfg_r),
    .in_op             (in_ch.op),
    .in_raw_goal       (in_ch.raw_goal),
    .in_measured_pos   (in_ch.measured_pos),
    .in_step_time      (in_ch.step_time),
    .stat              (stat),
    .out_safe_pos      (out_ch.safe_pos),
    .out_safe_speed    (out_ch.safe_speed),
    .out_valid_res     (out_ch.valid_res),
    .out_pos_clipped   (out_ch.pos_clipped),
    .out_speed_clipped (out_ch.speed_clipped),
    .out_accel_clipped (out_ch.accel_clipped),
    .out_track_clipped (out_ch.track_clipped),
    .out_goal_gap      (out_ch.goal_gap)
  );

endmodule
